// ===== hdl/tts_pkg.sv =====
// Shared types, constants and a helper function for the tunnel texture shader.
package tts_pkg;

    // Texture geometry: 64 x 64 texels of RGB565
    localparam int TEX_COORD_W = 6;
    localparam int TEX_DEPTH   = 4096;
    localparam int TEX_ADDR_W  = $clog2(TEX_DEPTH);
    localparam int TEXEL_W     = 16;

    // Frame coordinates and twiddled address
    localparam int PIX_W   = 7;
    localparam int ADDR_W  = 2 * PIX_W;
    localparam int FOG_W   = 5;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;

    // Queue between front and back
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Stream widths
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 32;

    // Item kinds carried on s_tuser
    typedef enum logic {
        CMD_LOAD   = 1'b0,
        CMD_RENDER = 1'b1
    } cmd_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROT_OFFSET = 1'b0,
        CFG_FWD_OFFSET = 1'b1
    } cfg_idx_t;

    // Input tdata layout, lowest field last
    typedef struct packed {
        logic [4:0]             pad;
        logic [FOG_W-1:0]       fog;
        logic [TEX_COORD_W-1:0] v_base;
        logic [TEX_COORD_W-1:0] u_base;
        logic [PIX_W-1:0]       pixel_y;
        logic [PIX_W-1:0]       pixel_x;
        logic [TEXEL_W-1:0]     texel_data;
        logic [TEX_ADDR_W-1:0]  texel_addr;
    } in_data_t;

    // Output tdata layout, lowest field last
    typedef struct packed {
        logic [1:0]          pad;
        logic [TEXEL_W-1:0]  out_color;
        logic [ADDR_W-1:0]   out_addr;
    } out_data_t;

    // One render pixel waiting for shading
    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [FOG_W-1:0]   fog;
        logic [TEXEL_W-1:0] texel;
    } pix_t;

    // Morton interleave: y bit k to 2k, x bit k to 2k+1
    function automatic logic [ADDR_W-1:0] twiddle(input logic [PIX_W-1:0] x,
                                                   input logic [PIX_W-1:0] y);
        logic [ADDR_W-1:0] r;
        r = '0;
        for (int k = 0; k < PIX_W; k++) begin
            r[2*k]   = y[k];
            r[2*k+1] = x[k];
        end
        return r;
    endfunction

endpackage

// ===== hdl/tts_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module tts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/tts_front.sv =====
// Front end: accepts items, holds offsets, writes texels and looks up render texels.
module tts_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_wr_en,
    input  logic [tts_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tts_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [tts_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                              s_tuser,
    // queue side
    input  logic [tts_pkg::QCNT_W-1:0]        q_count,
    output logic                              q_push,
    output tts_pkg::pix_t                     q_entry
);

    tts_pkg::in_data_t                    in_d;
    logic                                 accept;
    logic                                 is_render;
    logic [tts_pkg::TEX_COORD_W-1:0]      u_coord;
    logic [tts_pkg::TEX_COORD_W-1:0]      v_coord;
    logic [tts_pkg::TEXEL_W-1:0]          ram_rdata;

    logic [tts_pkg::TEX_COORD_W-1:0]      rot_reg, rot_next;
    logic [tts_pkg::TEX_COORD_W-1:0]      fwd_reg, fwd_next;
    logic                                 stage_valid_reg, stage_valid_next;
    logic [tts_pkg::ADDR_W-1:0]           stage_addr_reg, stage_addr_next;
    logic [tts_pkg::FOG_W-1:0]            stage_fog_reg, stage_fog_next;

    assign in_d      = tts_pkg::in_data_t'(s_tdata);
    assign accept    = s_tvalid && s_tready;
    assign is_render = (tts_pkg::cmd_t'(s_tuser) == tts_pkg::CMD_RENDER);

    // credit check: queued entries plus the one in the lookup stage
    assign s_tready = ({1'b0, q_count} + {{tts_pkg::QCNT_W{1'b0}}, stage_valid_reg})
                      < (tts_pkg::QCNT_W + 1)'(tts_pkg::QDEPTH);

    // offset registers
    always_comb begin
        rot_next = rot_reg;
        fwd_next = fwd_reg;
        if (cfg_wr_en) begin
            case (tts_pkg::cfg_idx_t'(cfg_index))
                tts_pkg::CFG_ROT_OFFSET: rot_next = cfg_wdata;
                tts_pkg::CFG_FWD_OFFSET: fwd_next = cfg_wdata;
                default: ;
            endcase
        end
    end

    // texture coordinates wrap at the texture size
    assign u_coord = in_d.u_base + rot_reg;
    assign v_coord = in_d.v_base + fwd_reg;

    tts_ram #(
        .WIDTH (tts_pkg::TEXEL_W),
        .DEPTH (tts_pkg::TEX_DEPTH)
    ) u_tex_ram (
        .aclk  (aclk),
        .we    (accept && !is_render),
        .waddr (in_d.texel_addr),
        .wdata (in_d.texel_data),
        .raddr ({v_coord, u_coord}),
        .rdata (ram_rdata)
    );

    // lookup stage holds the pixel while the texture RAM read completes
    always_comb begin
        stage_valid_next = accept && is_render;
        stage_addr_next  = tts_pkg::twiddle(in_d.pixel_x, in_d.pixel_y);
        stage_fog_next   = in_d.fog;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rot_reg         <= '0;
            fwd_reg         <= '0;
            stage_valid_reg <= 1'b0;
        end else begin
            rot_reg         <= rot_next;
            fwd_reg         <= fwd_next;
            stage_valid_reg <= stage_valid_next;
        end
        stage_addr_reg <= stage_addr_next;
        stage_fog_reg  <= stage_fog_next;
    end

    assign q_push        = stage_valid_reg;
    assign q_entry.addr  = stage_addr_reg;
    assign q_entry.fog   = stage_fog_reg;
    assign q_entry.texel = ram_rdata;

endmodule

// ===== hdl/tts_fifo.sv =====
// Short queue of looked-up pixels between front and back.
module tts_fifo (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        push,
    input  tts_pkg::pix_t               push_entry,
    input  logic                        pop,
    output logic                        head_valid,
    output tts_pkg::pix_t               head_entry,
    output logic [tts_pkg::QCNT_W-1:0]  count
);

    tts_pkg::pix_t                mem_reg [tts_pkg::QDEPTH];
    logic [tts_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [tts_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [tts_pkg::QCNT_W-1:0]   count_reg, count_next;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == tts_pkg::QPTR_W'(tts_pkg::QDEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == tts_pkg::QPTR_W'(tts_pkg::QDEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head_valid = (count_reg != '0);
    assign head_entry = mem_reg[rd_ptr_reg];
    assign count      = count_reg;

endmodule

// ===== hdl/tts_back.sv =====
// Back end: applies fog to each RGB565 channel and drives the output register.
module tts_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           head_valid,
    input  tts_pkg::pix_t                  head_entry,
    output logic                           pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [tts_pkg::M_TDATA_W-1:0]  m_tdata
);

    logic [9:0]                       r_prod;
    logic [10:0]                      g_prod;
    logic [9:0]                       b_prod;
    tts_pkg::out_data_t               out_d;
    logic                             m_valid_reg, m_valid_next;
    logic [tts_pkg::M_TDATA_W-1:0]    m_data_reg, m_data_next;

    // take the head when the output register is free or draining
    assign pop = head_valid && (!m_valid_reg || m_tready);

    // channel * fog, truncated by 32
    assign r_prod = {5'b0, head_entry.texel[15:11]} * {5'b0, head_entry.fog};
    assign g_prod = {5'b0, head_entry.texel[10:5]}  * {6'b0, head_entry.fog};
    assign b_prod = {5'b0, head_entry.texel[4:0]}   * {5'b0, head_entry.fog};

    always_comb begin
        out_d.pad       = '0;
        out_d.out_addr  = head_entry.addr;
        out_d.out_color = {r_prod[9:5], g_prod[10:5], b_prod[9:5]};
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (pop) begin
            m_valid_next = 1'b1;
            m_data_next  = out_d;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== hdl/tunnel_texture_shade_twiddle_core.sv =====
// Top level of the tunnel texture shader with twiddled output addresses.
//
//  channel  dir  handshake            payload
//  s_       in   s_tvalid/s_tready    s_tdata (texel/pixel fields), s_tuser (cmd)
//  m_       out  m_tvalid/m_tready    m_tdata (out_addr, out_color)
//  cfg_     in   cfg_wr_en            cfg_index, cfg_wdata (offset registers)
//
// One item per cycle sustained while m_tready stays high. A render result passes
// through texture RAM read, queue write, shading into the output register.
// Load items write the texture RAM at acceptance and give no result.
// s_tready drops once the queued pixels plus the one in the lookup stage reach
// the queue depth of 4, which happens only while m_tready is held low.
// Synchronous active-low reset; the texture RAM is not cleared.
module tunnel_texture_shade_twiddle_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [tts_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tts_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // texel_addr, texel_data, pixel_x, pixel_y, u_base, v_base, fog, zero pad
    input  logic [tts_pkg::S_TDATA_W-1:0]     s_tdata,
    // cmd
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // out_addr, out_color, zero pad
    output logic [tts_pkg::M_TDATA_W-1:0]     m_tdata
);

    logic                           q_push;
    tts_pkg::pix_t                  q_entry;
    logic                           q_pop;
    logic                           q_head_valid;
    tts_pkg::pix_t                  q_head;
    logic [tts_pkg::QCNT_W-1:0]     q_count;

    tts_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_count   (q_count),
        .q_push    (q_push),
        .q_entry   (q_entry)
    );

    tts_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_entry (q_head),
        .count      (q_count)
    );

    tts_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_head_valid),
        .head_entry (q_head),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule
